// ===== rtl/bis_pkg.sv =====
// Shared types, constants and helpers of the bilinear image sampler.
package bis_pkg;

	localparam int COORD_BITS = 26;
	localparam int FRAC_BITS = 16;
	localparam int PIXEL_BITS = 16;
	localparam int COL_BITS = 7;
	localparam int ROW_BITS = 7;
	localparam int CFG_BITS = 8;
	localparam int CFG_RESET = 128;
	localparam int DEF_MAX_WIDTH = 128;
	localparam int DEF_MAX_HEIGHT = 128;
	localparam int APB_ADDR_BITS = 3;
	localparam int APB_DATA_BITS = 32;

	localparam logic [FRAC_BITS:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

	typedef enum logic {
		ACT_WRITE  = 1'b0,
		ACT_SAMPLE = 1'b1
	} action_t;

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic s1;
		logic s2;
	} axis_en_t;

	typedef struct packed {
		logic s4;
		logic s5;
		logic s6;
		logic s7;
	} blend_en_t;

	// Size in use: zero reads as one, anything above the store saturates.
	function automatic int unsigned eff_size(input int unsigned raw, input int unsigned maxv);
		int unsigned res;
		if (raw == 0) begin
			res = 1;
		end else if (raw > maxv) begin
			res = maxv;
		end else begin
			res = raw;
		end
		return res;
	endfunction

endpackage

// ===== rtl/bis_in_if.sv =====
// Input channel: pixel writes and sample requests.
interface bis_in_if;
	logic                                     valid;
	logic                                     ready;
	logic                                     action;
	logic        [bis_pkg::COL_BITS-1:0]      pixel_column;
	logic        [bis_pkg::ROW_BITS-1:0]      pixel_row;
	logic        [bis_pkg::PIXEL_BITS-1:0]    pixel_value;
	logic signed [bis_pkg::COORD_BITS-1:0]    sample_x;
	logic signed [bis_pkg::COORD_BITS-1:0]    sample_y;
	logic                                     normalized;

	modport source (
		output valid, action, pixel_column, pixel_row, pixel_value,
		output sample_x, sample_y, normalized,
		input  ready
	);
	modport sink (
		input  valid, action, pixel_column, pixel_row, pixel_value,
		input  sample_x, sample_y, normalized,
		output ready
	);
endinterface

// ===== rtl/bis_out_if.sv =====
// Output channel: interpolated sample values.
interface bis_out_if;
	logic                               valid;
	logic                               ready;
	logic [bis_pkg::PIXEL_BITS-1:0]     sample_value;

	modport source (output valid, sample_value, input ready);
	modport sink (input valid, sample_value, output ready);
endinterface

// ===== rtl/bis_ram.sv =====
// Generic simple dual-port RAM with registered read.
module bis_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/bis_axis.sv =====
// One coordinate axis: scale, half-pixel offset, clamp, neighbor indices and fraction.
module bis_axis #(
	parameter int MAX_SIZE = bis_pkg::DEF_MAX_WIDTH,
	localparam int SW = $clog2(MAX_SIZE + 1),
	localparam int IW = $clog2(MAX_SIZE)
) (
	input  logic                                    clk,
	input  bis_pkg::axis_en_t                       en,
	input  logic signed [bis_pkg::COORD_BITS-1:0]   coord,
	input  logic                                    normalized,
	input  logic        [SW-1:0]                    size,
	output logic        [IW-1:0]                    idx0,
	output logic        [IW-1:0]                    idx1,
	output logic                                    same,
	output logic        [bis_pkg::FRAC_BITS:0]      frac
);

	localparam int F  = bis_pkg::FRAC_BITS;
	localparam int PW = bis_pkg::COORD_BITS + SW + 1;
	localparam int CW = SW + F;
	localparam logic signed [PW:0] HALF = (PW + 1)'(1) << (F - 1);

	logic signed [PW-1:0] scaled;
	logic signed [PW-1:0] scaled_s1;
	logic signed [PW:0]   shifted;
	logic signed [PW:0]   lim_ext;
	logic        [CW-1:0] lim;
	logic        [CW-1:0] clamped;
	logic        [CW-1:0] clamped_s2;
	logic        [SW-1:0] whole;
	logic        [SW-1:0] idx0_full;
	logic                 at_end;

	always_comb begin
		if (normalized) begin
			scaled = PW'(coord) * PW'($signed({1'b0, size}));
		end else begin
			scaled = PW'(coord);
		end
	end

	assign lim     = {size, {F{1'b0}}};
	assign lim_ext = $signed((PW + 1)'(lim));
	assign shifted = (PW + 1)'(scaled_s1) - HALF;

	always_comb begin
		if (shifted < 0) begin
			clamped = '0;
		end else if (shifted > lim_ext) begin
			clamped = lim;
		end else begin
			clamped = shifted[CW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			scaled_s1 <= scaled;
		end
		if (en.s2) begin
			clamped_s2 <= clamped;
		end
	end

	// far edge: a whole pixel of fraction between two equal edge pixels
	assign whole     = clamped_s2[CW-1:F];
	assign at_end    = (whole == size);
	assign idx0_full = at_end ? (size - SW'(1)) : whole;
	assign same      = (idx0_full == (size - SW'(1)));
	assign idx0      = idx0_full[IW-1:0];
	assign idx1      = same ? idx0 : (idx0 + IW'(1));
	assign frac      = at_end ? bis_pkg::FRAC_ONE : {1'b0, clamped_s2[F-1:0]};

endmodule

// ===== rtl/bis_blend.sv =====
// Bilinear blend: y products, y sums, x products, rounding and output register.
module bis_blend (
	input  logic                                clk,
	input  bis_pkg::blend_en_t                  en,
	input  logic [bis_pkg::PIXEL_BITS-1:0]      p00,
	input  logic [bis_pkg::PIXEL_BITS-1:0]      p01,
	input  logic [bis_pkg::PIXEL_BITS-1:0]      p10,
	input  logic [bis_pkg::PIXEL_BITS-1:0]      p11,
	input  logic [bis_pkg::FRAC_BITS:0]         xf,
	input  logic [bis_pkg::FRAC_BITS:0]         yf,
	output logic [bis_pkg::PIXEL_BITS-1:0]      sample_value
);

	localparam int F  = bis_pkg::FRAC_BITS;
	localparam int P  = bis_pkg::PIXEL_BITS;
	localparam int AW = P + F + 1;
	localparam int CW = P + 2 * F + 1;
	localparam logic [CW-1:0] ROUND = CW'(1) << (2 * F - 1);

	logic [F:0]    yw;
	logic [F:0]    xw;
	logic [AW-1:0] a0_s4, a1_s4, b0_s4, b1_s4;
	logic [F:0]    xf_s4, xf_s5;
	logic [AW-1:0] v0_sum, v1_sum;
	logic [AW-2:0] v0_s5, v1_s5;
	logic [CW-1:0] c0_s6, c1_s6;
	logic [CW-1:0] total;

	assign yw     = bis_pkg::FRAC_ONE - yf;
	assign xw     = bis_pkg::FRAC_ONE - xf_s5;
	assign v0_sum = a0_s4 + a1_s4;
	assign v1_sum = b0_s4 + b1_s4;
	assign total  = c0_s6 + c1_s6 + ROUND;

	always_ff @(posedge clk) begin
		if (en.s4) begin
			a0_s4 <= AW'(p00) * AW'(yw);
			a1_s4 <= AW'(p01) * AW'(yf);
			b0_s4 <= AW'(p10) * AW'(yw);
			b1_s4 <= AW'(p11) * AW'(yf);
			xf_s4 <= xf;
		end
		if (en.s5) begin
			v0_s5 <= v0_sum[AW-2:0];
			v1_s5 <= v1_sum[AW-2:0];
			xf_s5 <= xf_s4;
		end
		if (en.s6) begin
			c0_s6 <= CW'(v0_s5) * CW'(xw);
			c1_s6 <= CW'(v1_s5) * CW'(xf_s5);
		end
		if (en.s7) begin
			sample_value <= total[2*F +: P];
		end
	end

endmodule

// ===== rtl/bilinear_image_sampler.sv =====
// Top level of the bilinear image sampler with clamp-to-edge addressing.
// Takes one item (pixel write or sample) per clock and returns a sample result from the
// blend output register, with a full pipeline that only stalls where the output is not taken.
// The rate of one item per cycle is set by the pixel store: four banks split by column and
// row parity, each with one read or write per cycle, so the four neighbors of a sample come
// out in one access. Writes land at stage two; a later sample sees them. The store is not
// cleared after reset, and no sample may touch a pixel that was never written.
module bilinear_image_sampler #(
	parameter int MAX_WIDTH  = bis_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bis_pkg::DEF_MAX_HEIGHT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	bis_in_if.sink                              req,
	bis_out_if.source                           rsp,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [bis_pkg::APB_ADDR_BITS-1:0]   paddr,
	input  logic [bis_pkg::APB_DATA_BITS-1:0]   pwdata,
	output logic [bis_pkg::APB_DATA_BITS-1:0]   prdata,
	output logic                                pready
);

	localparam int F     = bis_pkg::FRAC_BITS;
	localparam int P     = bis_pkg::PIXEL_BITS;
	localparam int SWW   = $clog2(MAX_WIDTH + 1);
	localparam int SWH   = $clog2(MAX_HEIGHT + 1);
	localparam int XIW   = $clog2(MAX_WIDTH);
	localparam int YIW   = $clog2(MAX_HEIGHT);
	localparam int HCL   = $clog2((MAX_WIDTH + 1) / 2);
	localparam int HRL   = $clog2((MAX_HEIGHT + 1) / 2);
	localparam int HCW   = (HCL > 1) ? HCL : 1;
	localparam int HRW   = (HRL > 1) ? HRL : 1;
	localparam int BAW   = HCW + HRW;
	localparam int BANKS = 4;
	localparam int BANK_DEPTH = 2 ** BAW;
	localparam logic [SWW-1:0] EFF_W_RESET =
		SWW'(bis_pkg::eff_size(bis_pkg::CFG_RESET, MAX_WIDTH));
	localparam logic [SWH-1:0] EFF_H_RESET =
		SWH'(bis_pkg::eff_size(bis_pkg::CFG_RESET, MAX_HEIGHT));

	// configuration
	logic [bis_pkg::CFG_BITS-1:0] width_q, height_q;
	logic [SWW-1:0]               eff_w_q;
	logic [SWH-1:0]               eff_h_q;
	logic                         cfg_wr;

	// pipeline control
	logic en1, en2, en3, en4, en5, en6, en7;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	bis_pkg::axis_en_t  axis_en;
	bis_pkg::blend_en_t blend_en;

	// write path
	bis_pkg::action_t                action_s1, action_s2;
	logic [bis_pkg::COL_BITS-1:0]    col_s1, col_s2;
	logic [bis_pkg::ROW_BITS-1:0]    row_s1, row_s2;
	logic [P-1:0]                    value_s1, value_s2;
	logic [31:0]                     wcol_ext, wrow_ext;
	logic                            wr_go, rd_go;

	// axis results at stage two
	logic [XIW-1:0] x_idx0, x_idx1;
	logic [YIW-1:0] y_idx0, y_idx1;
	logic           x_same, y_same;
	logic [F:0]     x_frac, y_frac;

	// stage three
	logic           x0par_s3, y0par_s3, xsame_s3, ysame_s3;
	logic [F:0]     xf_s3, yf_s3;
	logic           x1par, y1par;
	logic [P-1:0]   bank_rd [BANKS];
	logic [BANKS-1:0] bank_we;
	logic [P-1:0]   p00, p01, p10, p11;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bis_pkg::CFG_BITS'(bis_pkg::CFG_RESET);
			height_q <= bis_pkg::CFG_BITS'(bis_pkg::CFG_RESET);
			eff_w_q  <= EFF_W_RESET;
			eff_h_q  <= EFF_H_RESET;
		end else if (cfg_wr) begin
			case (bis_pkg::cfg_reg_t'(paddr[2]))
				bis_pkg::REG_WIDTH: begin
					width_q <= pwdata[bis_pkg::CFG_BITS-1:0];
					eff_w_q <= SWW'(bis_pkg::eff_size(32'(pwdata[bis_pkg::CFG_BITS-1:0]),
						MAX_WIDTH));
				end
				bis_pkg::REG_HEIGHT: begin
					height_q <= pwdata[bis_pkg::CFG_BITS-1:0];
					eff_h_q  <= SWH'(bis_pkg::eff_size(32'(pwdata[bis_pkg::CFG_BITS-1:0]),
						MAX_HEIGHT));
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (bis_pkg::cfg_reg_t'(paddr[2]))
			bis_pkg::REG_WIDTH:  prdata = bis_pkg::APB_DATA_BITS'(width_q);
			bis_pkg::REG_HEIGHT: prdata = bis_pkg::APB_DATA_BITS'(height_q);
			default:             prdata = '0;
		endcase
	end

	// each stage moves when empty or when the one after it moves
	assign en7 = !valid_s7 | rsp.ready;
	assign en6 = !valid_s6 | en7;
	assign en5 = !valid_s5 | en6;
	assign en4 = !valid_s4 | en5;
	assign en3 = !valid_s3 | en4;
	assign en2 = !valid_s2 | en3;
	assign en1 = !valid_s1 | en2;

	assign req.ready = en1;
	assign rsp.valid = valid_s7;

	assign axis_en  = '{s1: en1, s2: en2};
	assign blend_en = '{s4: en4, s5: en5, s6: en6, s7: en7};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= req.valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2 & (action_s2 == bis_pkg::ACT_SAMPLE);
			if (en4) valid_s4 <= valid_s3;
			if (en5) valid_s5 <= valid_s4;
			if (en6) valid_s6 <= valid_s5;
			if (en7) valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			action_s1 <= bis_pkg::action_t'(req.action);
			col_s1    <= req.pixel_column;
			row_s1    <= req.pixel_row;
			value_s1  <= req.pixel_value;
		end
		if (en2) begin
			action_s2 <= action_s1;
			col_s2    <= col_s1;
			row_s2    <= row_s1;
			value_s2  <= value_s1;
		end
		if (en3) begin
			x0par_s3 <= x_idx0[0];
			y0par_s3 <= y_idx0[0];
			xsame_s3 <= x_same;
			ysame_s3 <= y_same;
			xf_s3    <= x_frac;
			yf_s3    <= y_frac;
		end
	end

	bis_axis #(.MAX_SIZE(MAX_WIDTH)) u_axis_x (
		.clk        (clk),
		.en         (axis_en),
		.coord      (req.sample_x),
		.normalized (req.normalized),
		.size       (eff_w_q),
		.idx0       (x_idx0),
		.idx1       (x_idx1),
		.same       (x_same),
		.frac       (x_frac)
	);

	bis_axis #(.MAX_SIZE(MAX_HEIGHT)) u_axis_y (
		.clk        (clk),
		.en         (axis_en),
		.coord      (req.sample_y),
		.normalized (req.normalized),
		.size       (eff_h_q),
		.idx0       (y_idx0),
		.idx1       (y_idx1),
		.same       (y_same),
		.frac       (y_frac)
	);

	assign wcol_ext = 32'(col_s2);
	assign wrow_ext = 32'(row_s2);
	assign wr_go = valid_s2 & (action_s2 == bis_pkg::ACT_WRITE) & en3
		& (wcol_ext < 32'(MAX_WIDTH)) & (wrow_ext < 32'(MAX_HEIGHT));
	assign rd_go = valid_s2 & (action_s2 == bis_pkg::ACT_SAMPLE) & en3;

	// bank {row parity, column parity}
	for (genvar b = 0; b < BANKS; b++) begin : g_bank
		localparam logic PC = 1'(b % 2);
		localparam logic PR = 1'(b / 2);
		logic [XIW-1:0] col_rd;
		logic [YIW-1:0] row_rd;
		logic [31:0]    col_ext;
		logic [31:0]    row_ext;
		logic [BAW-1:0] raddr;
		logic [BAW-1:0] waddr;

		assign col_rd  = (x_idx0[0] == PC) ? x_idx0 : x_idx1;
		assign row_rd  = (y_idx0[0] == PR) ? y_idx0 : y_idx1;
		assign col_ext = 32'(col_rd);
		assign row_ext = 32'(row_rd);
		assign raddr   = {row_ext[HRW:1], col_ext[HCW:1]};
		assign waddr   = {wrow_ext[HRW:1], wcol_ext[HCW:1]};
		assign bank_we[b] = wr_go & (wcol_ext[0] == PC) & (wrow_ext[0] == PR);

		bis_ram #(.WIDTH(P), .DEPTH(BANK_DEPTH)) u_ram (
			.clk   (clk),
			.we    (bank_we[b]),
			.waddr (waddr),
			.wdata (value_s2),
			.re    (rd_go),
			.raddr (raddr),
			.rdata (bank_rd[b])
		);
	end

	assign x1par = x0par_s3 ^ !xsame_s3;
	assign y1par = y0par_s3 ^ !ysame_s3;
	assign p00 = bank_rd[{y0par_s3, x0par_s3}];
	assign p01 = bank_rd[{y1par, x0par_s3}];
	assign p10 = bank_rd[{y0par_s3, x1par}];
	assign p11 = bank_rd[{y1par, x1par}];

	bis_blend u_blend (
		.clk          (clk),
		.en           (blend_en),
		.p00          (p00),
		.p01          (p01),
		.p10          (p10),
		.p11          (p11),
		.xf           (xf_s3),
		.yf           (yf_s3),
		.sample_value (rsp.sample_value)
	);

	a_rd_wr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_go && (bank_we != '0)))
		else $error("bank read and write in the same cycle");

	a_one_bank_wr: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(bank_we))
		else $error("more than one bank written");

	a_x_edge: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (action_s2 == bis_pkg::ACT_SAMPLE) && (x_frac == bis_pkg::FRAC_ONE))
		|-> x_same)
		else $error("full x fraction away from the far edge");

	a_y_edge: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (action_s2 == bis_pkg::ACT_SAMPLE) && (y_frac == bis_pkg::FRAC_ONE))
		|-> y_same)
		else $error("full y fraction away from the far edge");

endmodule
